// ===== src/rnpf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rnpf_pkg;

    localparam int FRAME_BYTES  = 64;
    localparam int HEADER_BYTES = 7;
    localparam int POS_W        = $clog2(FRAME_BYTES);
    localparam int TOT_W        = 9;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    localparam logic [1:0] REG_NODE  = 2'd0;
    localparam logic [1:0] REG_BCAST = 2'd1;
    localparam logic [1:0] REG_TTL   = 2'd2;

    typedef struct packed {
        logic [7:0] node_addr;
        logic [7:0] bcast_addr;
        logic [7:0] ttl_limit;
    } t_cfg;

    // One queued job: either the header burst at the ttl byte or a single packet byte
    typedef struct packed {
        logic       hdr_burst;
        logic       fwd;
        logic       dlv;
        logic       pend;
        logic [7:0] data;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] h2;
    } t_job;

endpackage

`default_nettype wire

// ===== src/ring_node_packet_filter_forward.sv =====
// Channel   | Direction | Handshake        | Words
// ----------+-----------+------------------+-----------------------------------------------
// rx        | in        | push / full      | i_rx_byte
// result    | out       | empty / pop      | o_to_link, o_data_byte, o_packet_end, o_run_last
// config    | in        | APB psel/penable | node, broadcast, ttl_limit at 0x0, 0x4, 0x8
//
// One rx word is taken per cycle while the four-entry job queue has room.
// The back end sends one result word per cycle while results are popped; the ttl
// byte yields up to eight, other bytes up to two, so rx stalls (full) when those
// bursts outrun the queue or when the result side holds off.
// A result word passes the job queue and then the output register to reach the ports.
// Synchronous reset clears all control state.
`timescale 1ns / 1ps
`default_nettype none

module ring_node_packet_filter_forward (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_rx_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_to_link,
    output logic [7:0]       o_data_byte,
    output logic             o_packet_end,
    output logic             o_run_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rnpf_pkg::*;

    t_cfg       r_cfg;
    t_job       w_job_in, w_job_out;
    logic       w_acc, w_job_vld, w_job_rd, w_job_empty, w_cfg_wr;
    logic [1:0] w_idx;

    assign pready   = 1'b1;
    assign w_idx    = paddr[3:2];
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_acc    = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_addr  <= 8'd0;
            r_cfg.bcast_addr <= 8'd255;
            r_cfg.ttl_limit  <= 8'd16;
        end else if (w_cfg_wr) begin
            case (w_idx)
                REG_NODE:  r_cfg.node_addr  <= pwdata[7:0];
                REG_BCAST: r_cfg.bcast_addr <= pwdata[7:0];
                REG_TTL:   r_cfg.ttl_limit  <= pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_NODE:  prdata = {24'd0, r_cfg.node_addr};
            REG_BCAST: prdata = {24'd0, r_cfg.bcast_addr};
            REG_TTL:   prdata = {24'd0, r_cfg.ttl_limit};
            default:   prdata = 32'd0;
        endcase
    end

    rnpf_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (w_acc),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_job_vld (w_job_vld),
        .o_job     (w_job_in)
    );

    rnpf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_job_vld),
        .i_wdata (w_job_in),
        .i_rd    (w_job_rd),
        .o_rdata (w_job_out),
        .o_full  (full),
        .o_empty (w_job_empty)
    );

    rnpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_job_out),
        .i_job_empty  (w_job_empty),
        .o_job_rd     (w_job_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_to_link    (o_to_link),
        .o_data_byte  (o_data_byte),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last)
    );

endmodule

`default_nettype wire

// ===== src/rnpf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnpf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_acc,
    input  wire logic [7:0]    i_rx_byte,
    input  wire rnpf_pkg::t_cfg i_cfg,
    output logic               o_job_vld,
    output rnpf_pkg::t_job     o_job
);
    import rnpf_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_hdr [3];
    logic [7:0]       r_len, n_len;
    logic             r_fwd, n_fwd;
    logic             r_dlv, n_dlv;

    logic             w_to_me, w_bcast, w_own_bcast, w_ttl_ok;
    logic [7:0]       w_len_eff;
    logic [TOT_W-1:0] w_sum, w_total, w_pos_ext;

    assign w_to_me     = r_hdr[2] == i_cfg.node_addr;
    assign w_bcast     = r_hdr[2] == i_cfg.bcast_addr;
    assign w_own_bcast = w_bcast && (r_hdr[1] == i_cfg.node_addr);
    assign w_ttl_ok    = (i_rx_byte != 8'd0) && (i_rx_byte <= i_cfg.ttl_limit);

    assign w_len_eff = (r_pos == POS_W'(4)) ? i_rx_byte : r_len;
    assign w_sum     = TOT_W'(w_len_eff) + TOT_W'(HEADER_BYTES);
    assign w_total   = (w_sum > TOT_W'(FRAME_BYTES)) ? TOT_W'(FRAME_BYTES) : w_sum;
    assign w_pos_ext = TOT_W'(r_pos);

    always_comb begin
        n_pos     = (r_pos == POS_W'(FRAME_BYTES - 1)) ? '0 : r_pos + POS_W'(1);
        n_len     = r_len;
        n_fwd     = r_fwd;
        n_dlv     = r_dlv;
        o_job_vld = 1'b0;
        o_job.hdr_burst = 1'b0;
        o_job.fwd  = r_fwd;
        o_job.dlv  = r_dlv;
        o_job.pend = (w_pos_ext + TOT_W'(1)) == w_total;
        o_job.data = i_rx_byte;
        o_job.h0   = r_hdr[0];
        o_job.h1   = r_hdr[1];
        o_job.h2   = r_hdr[2];

        if (r_pos < POS_W'(3)) begin
            if (r_pos == '0) begin
                n_fwd = 1'b0;
                n_dlv = 1'b0;
                n_len = 8'd0;
            end
        end else if (r_pos == POS_W'(3)) begin
            n_dlv = w_to_me || w_bcast;
            n_fwd = !w_to_me && !w_own_bcast && w_ttl_ok;
            o_job.hdr_burst = 1'b1;
            o_job.fwd  = n_fwd;
            o_job.dlv  = n_dlv;
            o_job.pend = 1'b0;
            o_job_vld  = i_acc && (n_fwd || n_dlv);
        end else begin
            if (r_pos == POS_W'(4)) begin
                n_len = i_rx_byte;
            end
            o_job_vld = i_acc && (w_pos_ext < w_total) && (r_fwd || r_dlv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= 8'd0;
            r_fwd <= 1'b0;
            r_dlv <= 1'b0;
        end else if (i_acc) begin
            r_pos <= n_pos;
            r_len <= n_len;
            r_fwd <= n_fwd;
            r_dlv <= n_dlv;
        end
    end

    // held start, src, dest bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr[0] <= 8'd0;
            r_hdr[1] <= 8'd0;
            r_hdr[2] <= 8'd0;
        end else if (i_acc && (r_pos < POS_W'(3))) begin
            r_hdr[r_pos[1:0]] <= i_rx_byte;
        end
    end

endmodule

`default_nettype wire

// ===== src/rnpf_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnpf_fifo (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_wr,
    input  wire rnpf_pkg::t_job i_wdata,
    input  wire logic      i_rd,
    output rnpf_pkg::t_job o_rdata,
    output logic           o_full,
    output logic           o_empty
);
    import rnpf_pkg::*;

    t_job               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, r_rptr;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_wr, w_rd;

    assign o_full  = r_cnt == (FIFO_AW + 1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_wr) r_wptr <= r_wptr + FIFO_AW'(1);
            if (w_rd) r_rptr <= r_rptr + FIFO_AW'(1);
            if (w_wr && !w_rd) r_cnt <= r_cnt + (FIFO_AW + 1)'(1);
            else if (w_rd && !w_wr) r_cnt <= r_cnt - (FIFO_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// ===== src/rnpf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnpf_back (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire rnpf_pkg::t_job i_job,
    input  wire logic      i_job_empty,
    output logic           o_job_rd,
    input  wire logic      i_pop,
    output logic           o_empty,
    output logic           o_to_link,
    output logic [7:0]     o_data_byte,
    output logic           o_packet_end,
    output logic           o_run_last
);
    import rnpf_pkg::*;

    logic       r_host_ph;
    logic [1:0] r_idx;
    logic       r_vld;
    logic       r_link, r_end, r_last;
    logic [7:0] r_byte;

    logic       w_emit, w_host, w_last_ph, w_last_job;
    logic [7:0] w_byte;

    // link copy first when forwarded, then the host copy
    assign w_host     = r_host_ph || !i_job.fwd;
    assign w_last_ph  = !i_job.hdr_burst || (r_idx == 2'd3);
    assign w_last_job = w_last_ph && (w_host || !i_job.dlv);
    assign w_emit     = !i_job_empty && (!r_vld || i_pop);
    assign o_job_rd   = w_emit && w_last_job;

    always_comb begin
        if (!i_job.hdr_burst) begin
            w_byte = i_job.data;
        end else begin
            case (r_idx)
                2'd0:    w_byte = i_job.h0;
                2'd1:    w_byte = i_job.h1;
                2'd2:    w_byte = i_job.h2;
                default: w_byte = w_host ? i_job.data : i_job.data - 8'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_ph <= 1'b0;
            r_idx     <= 2'd0;
            r_vld     <= 1'b0;
        end else begin
            if (w_emit) begin
                r_vld <= 1'b1;
                if (w_last_job) begin
                    r_host_ph <= 1'b0;
                    r_idx     <= 2'd0;
                end else if (w_last_ph) begin
                    r_host_ph <= 1'b1;
                    r_idx     <= 2'd0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end else if (i_pop) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_link <= !w_host;
            r_byte <= w_byte;
            r_end  <= !i_job.hdr_burst && i_job.pend;
            r_last <= w_last_job;
        end
    end

    assign o_empty      = !r_vld;
    assign o_to_link    = r_link;
    assign o_data_byte  = r_byte;
    assign o_packet_end = r_end;
    assign o_run_last   = r_last;

endmodule

`default_nettype wire

// ===== src/rnpf_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnpf_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic        o_to_link,
    input wire logic [7:0]  o_data_byte,
    input wire logic        o_packet_end,
    input wire logic        o_run_last
);

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result word dropped");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> $stable(o_data_byte) && $stable(o_to_link))
        else $error("stalled result word changed");

    // host copy always comes last for its rx word
    a_host_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_packet_end && !o_to_link |-> o_run_last)
        else $error("host packet end without run_last");

endmodule

bind ring_node_packet_filter_forward rnpf_chk u_chk (.*);

`default_nettype wire

// ===== test/tb_ring_node_packet_filter_forward.sv =====
`timescale 1ns / 1ps

module tb_ring_node_packet_filter_forward;
    import rnpf_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;   // unmapped register slot
    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 10;
    localparam int STUCK_LIMIT = 4000;

    typedef struct packed {
        logic       link;
        logic [7:0] data;
        logic       pkt_end;
        logic       last;
    } t_ring_word;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        empty;
    logic        pop     = 1'b0;
    logic        o_to_link;
    logic [7:0]  o_data_byte;
    logic        o_packet_end;
    logic        o_run_last;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'h0;
    logic [31:0] pwdata  = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    ring_node_packet_filter_forward u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_rx_byte    (i_rx_byte),
        .empty        (empty),
        .pop          (pop),
        .o_to_link    (o_to_link),
        .o_data_byte  (o_data_byte),
        .o_packet_end (o_packet_end),
        .o_run_last   (o_run_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // node settings as the filter should see them
    logic [7:0] my_addr = 8'd0;
    logic [7:0] bc_addr = 8'd255;
    logic [7:0] ttl_max = 8'd16;

    // frame tracking state
    int         fpos = 0;
    logic [7:0] hdr [3] = '{8'h00, 8'h00, 8'h00};
    logic [7:0] plen = 8'h00;
    logic       fwd_on = 1'b0;
    logic       dlv_on = 1'b0;

    logic [7:0] rx_pending [$];
    t_ring_word words_due [$];

    int  errors      = 0;
    int  bytes_in    = 0;
    int  live_bytes  = 0;
    int  words_out   = 0;
    int  frames_sent = 0;
    int  settings    = 0;
    bit  steady      = 1'b0;
    bit  hold_armed  = 1'b0;
    bit  hold_done   = 1'b0;
    int  hold_cnt    = 0;
    int  stuck       = 0;

    function automatic void add_word(input logic link, input logic [7:0] data,
                                     input logic pkt_end);
        t_ring_word w;
        w = '{link: link, data: data, pkt_end: pkt_end, last: 1'b0};
        words_due.push_back(w);
    endfunction

    // one link byte in, the host / link words it should cause out
    function automatic int filter_rx_byte(input logic [7:0] b);
        int   start_sz;
        int   total;
        int   i;
        logic to_me;
        logic bc_hit;
        logic own_bc;
        start_sz = words_due.size();
        if (fpos < 3) begin
            if (fpos == 0) begin
                fwd_on = 1'b0;
                dlv_on = 1'b0;
                plen   = 8'h00;
            end
            hdr[fpos] = b;
        end else if (fpos == 3) begin
            to_me  = hdr[2] == my_addr;
            bc_hit = hdr[2] == bc_addr;
            own_bc = bc_hit && hdr[1] == my_addr;
            dlv_on = to_me || bc_hit;
            fwd_on = !to_me && !own_bc && b != 8'd0 && b <= ttl_max;
            if (fwd_on) begin
                for (i = 0; i < 3; i++) add_word(1'b1, hdr[i], 1'b0);
                add_word(1'b1, 8'(b - 8'd1), 1'b0);
            end
            if (dlv_on) begin
                for (i = 0; i < 3; i++) add_word(1'b0, hdr[i], 1'b0);
                add_word(1'b0, b, 1'b0);
            end
        end else begin
            if (fpos == 4) plen = b;
            total = HEADER_BYTES + int'(plen);
            if (total > FRAME_BYTES) total = FRAME_BYTES;
            if (fpos < total) begin
                if (fwd_on) add_word(1'b1, b, fpos + 1 == total);
                if (dlv_on) add_word(1'b0, b, fpos + 1 == total);
            end
        end
        fpos = (fpos == FRAME_BYTES - 1) ? 0 : fpos + 1;
        if (words_due.size() > start_sz) words_due[words_due.size() - 1].last = 1'b1;
        return words_due.size() - start_sz;
    endfunction

    function automatic void check_field(input string what, input int want_v, input int got_v);
        if (want_v != got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
        end
    endfunction

    // rx side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                bytes_in++;
                if (filter_rx_byte(i_rx_byte) > 0) live_bytes++;
            end
            if (!push || !full) begin
                if (rx_pending.size() != 0 && (steady || $urandom_range(99) >= 20)) begin
                    push      <= 1'b1;
                    i_rx_byte <= rx_pending.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_ring_word want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                words_out++;
                if (words_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got link=%0d data=0x%0h",
                             $time, o_to_link, o_data_byte);
                end else begin
                    want = words_due.pop_front();
                    check_field("to_link", want.link, o_to_link);
                    check_field("data_byte", want.data, o_data_byte);
                    check_field("packet_end", want.pkt_end, o_packet_end);
                    check_field("run_last", want.last, o_run_last);
                end
            end
            if (hold_cnt != 0) begin
                hold_cnt <= hold_cnt - 1;
                pop      <= 1'b0;
            end else if (hold_armed && !hold_done) begin
                hold_done <= 1'b1;
                hold_cnt  <= LONG_HOLD;
                pop       <= 1'b0;
            end else begin
                pop <= steady || $urandom_range(99) >= 20;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || psel || !i_rst_n) begin
            stuck <= 0;
        end else begin
            stuck <= stuck + 1;
        end
        if (stuck == STUCK_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STUCK_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_NODE:  my_addr = val;
            REG_BCAST: bc_addr = val;
            REG_TTL:   ttl_max = val;
            default:   ;
        endcase
    endtask

    task automatic set_node(input logic [7:0] node, input logic [7:0] bc,
                            input logic [7:0] ttl);
        cfg_write(REG_NODE, node);
        cfg_write(REG_BCAST, bc);
        cfg_write(REG_TTL, ttl);
        settings++;
    endtask

    task automatic queue_frame(input logic [7:0] sof, input logic [7:0] src,
                               input logic [7:0] dest, input logic [7:0] ttl,
                               input logic [7:0] len);
        int i;
        rx_pending.push_back(sof);
        rx_pending.push_back(src);
        rx_pending.push_back(dest);
        rx_pending.push_back(ttl);
        rx_pending.push_back(len);
        rx_pending.push_back(8'($urandom));
        rx_pending.push_back(8'($urandom));
        for (i = HEADER_BYTES; i < FRAME_BYTES; i++) rx_pending.push_back(8'($urandom));
        frames_sent++;
    endtask

    task automatic settle();
        do @(negedge i_clk); while (rx_pending.size() != 0 || push || words_due.size() != 0);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_node(8'h5A, 8'hFF, 8'd16);
        cfg_write(REG_SPARE, 8'h33);
        @(negedge i_clk);
        // long result-side stall with the link side still offering words
        hold_armed <= 1'b1;
        queue_frame(8'h00, 8'h11, 8'h5A, 8'd5, 8'd0);     // addressed here only
        queue_frame(8'hFF, 8'h22, 8'hFF, 8'd16, 8'd3);    // foreign broadcast, ttl at limit
        queue_frame(8'hA5, 8'h5A, 8'hFF, 8'd3, 8'd1);     // own broadcast back home
        queue_frame(8'h3C, 8'h33, 8'h44, 8'd1, 8'd2);     // forward, ttl hits zero
        queue_frame(8'h3C, 8'h33, 8'h00, 8'd0, 8'd2);     // ttl zero: dropped
        settle();

        // no idle cycles on either side
        steady = 1'b1;
        queue_frame(8'h7E, 8'h00, 8'hFF, 8'hFF, 8'd57);   // packet ends on last frame byte
        queue_frame(8'h81, 8'h01, 8'h02, 8'd2, 8'hFF);    // long len cut at frame end
        settle();
        steady = 1'b0;

        set_node(8'h5A, 8'hFF, 8'd0);                     // nothing may be forwarded
        @(negedge i_clk);
        queue_frame(8'h3C, 8'h33, 8'hFF, 8'd1, 8'd9);     // foreign broadcast, ttl above limit
        settle();

        $display("Sent %0d frames (%0d link bytes, %0d with results) under %0d node settings,",
                 frames_sent, bytes_in, live_bytes, settings);
        $display("checked %0d host/link words including a %0d-cycle output stall",
                 words_out, LONG_HOLD);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
